@@ sv/gfq_pkg.sv @@
`default_nettype none

package gfq_pkg;

	localparam int PID_W = 10;
	localparam int GID_W = 4;

	typedef enum logic [1:0] {
		CMD_ASSIGN = 2'd0,
		CMD_PUSH   = 2'd1,
		CMD_POP    = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_POPPED = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t             command;
		logic [PID_W-1:0] person_id;
		logic [GID_W-1:0] group_id;
	} item_t;

	typedef struct packed {
		status_t          status;
		logic [PID_W-1:0] popped_id;
		logic [GID_W-1:0] popped_group;
	} result_t;

endpackage

`default_nettype wire

@@ sv/gfq_ram.sv @@
`default_nettype none

// Simple dual-port RAM with a registered read; a read of the address being
// written in the same cycle returns the new data.
module gfq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    wa,
	input  logic [WIDTH-1:0] wd,
	input  logic [AW-1:0]    ra,
	output logic [WIDTH-1:0] rd
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= (we && (wa == ra)) ? wd : mem[ra];
	end

	assign rd = rd_q;

endmodule

`default_nettype wire

@@ sv/gfq_queue_ctl.sv @@
`default_nettype none

// Queue state and its update for one command. The slot store
// keeps, for each slot, the link to the next slot of its group and the
// identifier held there, so a pop needs only the record of the head slot.
// Both RAM reads are aimed at the next state's addresses, so their data is
// ready in the cycle the next command is worked on.
module gfq_queue_ctl #(
	parameter int NUM_GROUPS = 16,
	parameter int CAPACITY = 64,
	localparam int GW = $clog2(NUM_GROUPS),
	localparam int SW = $clog2(CAPACITY)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_vld,
	input  gfq_pkg::item_t   item,
	input  logic [GW-1:0]    push_grp,
	output gfq_pkg::result_t result
);

	localparam int PW = gfq_pkg::PID_W;
	localparam int RW = SW + PW;

	logic [SW-1:0]         head_slot_q [NUM_GROUPS];
	logic [SW-1:0]         tail_slot_q [NUM_GROUPS];
	logic [PW-1:0]         head_val_q  [NUM_GROUPS];
	logic [GW-1:0]         ring_q      [NUM_GROUPS];
	logic [NUM_GROUPS-1:0] present_q;
	logic [GW-1:0]         front_q;
	logic [GW:0]           count_q;
	logic [SW:0]           fresh_q;
	logic [SW:0]           rc_q;

	logic          rec_we;
	logic [SW-1:0] rec_wa;
	logic [RW-1:0] rec_wd;
	logic [SW-1:0] rec_ra;
	logic [RW-1:0] rec_rd;
	logic [SW-1:0] free_ra;
	logic [SW-1:0] free_rd;

	logic [GW-1:0] front_grp;
	logic [GW-1:0] front_inc;
	logic [GW-1:0] next_front_grp;
	logic [SW-1:0] pop_slot;
	logic          pop_last;
	logic          full;
	logic          empty;
	logic          do_push;
	logic          do_pop;
	logic          g_open;
	logic [SW-1:0] alloc;
	logic [GW+1:0] ring_sum;
	logic [GW+1:0] ring_wrap;
	logic [GW-1:0] ring_wa;
	logic [SW:0]   rc_next;
	logic [SW:0]   rc_dec;
	logic [GW+3:0] grp_ext;

	gfq_ram #(.WIDTH(RW), .DEPTH(CAPACITY)) u_slot_ram (
		.clk (clk),
		.we  (rec_we),
		.wa  (rec_wa),
		.wd  (rec_wd),
		.ra  (rec_ra),
		.rd  (rec_rd)
	);

	gfq_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_free_ram (
		.clk (clk),
		.we  (do_pop),
		.wa  (rc_q[SW-1:0]),
		.wd  (pop_slot),
		.ra  (free_ra),
		.rd  (free_rd)
	);

	assign front_grp      = ring_q[front_q];
	assign front_inc      = (front_q == GW'(NUM_GROUPS - 1)) ? '0 : front_q + 1'b1;
	assign next_front_grp = ring_q[front_inc];
	assign pop_slot       = head_slot_q[front_grp];
	assign pop_last       = (pop_slot == tail_slot_q[front_grp]);
	assign full           = (fresh_q == (SW+1)'(CAPACITY)) && (rc_q == '0);
	assign empty          = (count_q == '0);
	assign do_push        = item_vld && (item.command == gfq_pkg::CMD_PUSH) && !full;
	assign do_pop         = item_vld && (item.command == gfq_pkg::CMD_POP) && !empty;
	assign g_open         = !present_q[push_grp];
	assign alloc          = (rc_q != '0) ? free_rd : fresh_q[SW-1:0];

	assign ring_sum  = {2'b00, front_q} + {1'b0, count_q};
	assign ring_wrap = (ring_sum >= (GW+2)'(NUM_GROUPS)) ?
		ring_sum - (GW+2)'(NUM_GROUPS) : ring_sum;
	assign ring_wa   = ring_wrap[GW-1:0];

	// Appending behind an existing tail fills in the tail's record.
	assign rec_we = do_push && !g_open;
	assign rec_wa = tail_slot_q[push_grp];
	assign rec_wd = {alloc, item.person_id};

	// Head slot of the front group as it will be after this command.
	always_comb begin
		priority if (do_pop && !pop_last) begin
			rec_ra = rec_rd[RW-1:PW];
		end else if (do_pop) begin
			rec_ra = head_slot_q[next_front_grp];
		end else if (do_push && g_open && empty) begin
			rec_ra = alloc;
		end else begin
			rec_ra = pop_slot;
		end
	end

	always_comb begin
		priority if (do_pop) begin
			rc_next = rc_q + 1'b1;
		end else if (do_push && (rc_q != '0)) begin
			rc_next = rc_q - 1'b1;
		end else begin
			rc_next = rc_q;
		end
	end

	assign rc_dec  = rc_next - 1'b1;
	assign free_ra = rc_dec[SW-1:0];
	assign grp_ext = {4'b0000, front_grp};

	always_comb begin
		result.popped_id    = '0;
		result.popped_group = '0;
		unique case (item.command)
			gfq_pkg::CMD_PUSH: begin
				result.status = full ? gfq_pkg::ST_FULL : gfq_pkg::ST_DONE;
			end
			gfq_pkg::CMD_POP: begin
				if (empty) begin
					result.status = gfq_pkg::ST_EMPTY;
				end else begin
					result.status       = gfq_pkg::ST_POPPED;
					result.popped_id    = head_val_q[front_grp];
					result.popped_group = grp_ext[3:0];
				end
			end
			gfq_pkg::CMD_ASSIGN, gfq_pkg::CMD_NONE: begin
				result.status = gfq_pkg::ST_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			front_q   <= '0;
			count_q   <= '0;
			fresh_q   <= '0;
			rc_q      <= '0;
		end else begin
			rc_q    <= rc_next;
			fresh_q <= fresh_q + {{SW{1'b0}}, (do_push && (rc_q == '0))};
			if (do_push && g_open) begin
				present_q[push_grp] <= 1'b1;
				count_q             <= count_q + 1'b1;
			end
			if (do_pop && pop_last) begin
				present_q[front_grp] <= 1'b0;
				front_q              <= front_inc;
				count_q              <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			tail_slot_q[push_grp] <= alloc;
			if (g_open) begin
				head_slot_q[push_grp] <= alloc;
				head_val_q[push_grp]  <= item.person_id;
				ring_q[ring_wa]       <= push_grp;
			end
		end
		if (do_pop && !pop_last) begin
			head_slot_q[front_grp] <= rec_rd[RW-1:PW];
			head_val_q[front_grp]  <= rec_rd[PW-1:0];
		end
	end

endmodule

`default_nettype wire

@@ sv/group_fifo_queue.sv @@
`default_nettype none

// Team queue: identifiers are queued behind earlier members of their group,
// and groups are served in the order in which they first joined the queue.
// Commands come in on start/busy: an item is taken at a rising edge where
// start is high and busy is low. command selects assign (person_id joins
// group_id), push (person_id), pop or none; unused fields are ignored.
// Every item gives exactly one result: it passes the command register and
// then the result register and is put on status, popped_id and popped_group
// with valid high. The receiver has no way to stall, so results are never held
// back and nothing waits on the output side.
// One item is taken per cycle while busy is low. Each command is done by one
// pass of logic between the command register and the result register; the
// slot RAM and the free-slot RAM are read ahead at the addresses the next
// command will need, so consecutive pops of the same group do not wait.
// After reset the group map RAM is swept to group 0, one entry per cycle,
// across all ID_COUNT entries; busy is high for that whole time and low
// afterwards for good. Reset also empties the queue and frees every slot.
// A pop on an empty queue reports status 2, and a push with no free slot
// reports status 3; neither changes the queue.
module group_fifo_queue #(
	parameter int ID_COUNT = 1024,
	parameter int NUM_GROUPS = 16,
	parameter int CAPACITY = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] command,
	input  logic [9:0] person_id,
	input  logic [3:0] group_id,
	output logic       valid,
	output logic [1:0] status,
	output logic [9:0] popped_id,
	output logic [3:0] popped_group
);

	localparam int IAW = $clog2(ID_COUNT);
	localparam int GW  = $clog2(NUM_GROUPS);
	localparam int PW  = gfq_pkg::PID_W;

	// Group map clearing sweep.
	logic           clearing_q;
	logic [IAW-1:0] clr_addr_q;

	// Command register and result register.
	logic             item_vld_s1;
	gfq_pkg::item_t   item_s1;
	logic             valid_s2;
	gfq_pkg::result_t result_s2;
	gfq_pkg::result_t core_result;

	logic            accept;
	logic [IAW+PW-1:0] pid_in_ext;
	logic [IAW+PW-1:0] pid_s1_ext;
	logic [GW+3:0]   gid_s1_ext;
	logic            pid_ok_s1;
	logic            gid_ok_s1;
	logic            map_we;
	logic [IAW-1:0]  map_wa;
	logic [GW-1:0]   map_wd;
	logic [GW-1:0]   map_rd;
	logic [GW-1:0]   push_grp;

	assign busy   = clearing_q;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == IAW'(ID_COUNT - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
			valid_s2    <= 1'b0;
		end else begin
			item_vld_s1 <= accept;
			valid_s2    <= item_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{command: gfq_pkg::cmd_t'(command), person_id: person_id,
				group_id: group_id};
		end
		if (item_vld_s1) begin
			result_s2 <= core_result;
		end
	end

	// Identifiers or groups beyond the configured ranges are not mapped;
	// an unmapped identifier pushes into group 0.
	assign pid_in_ext = {{IAW{1'b0}}, person_id};
	assign pid_s1_ext = {{IAW{1'b0}}, item_s1.person_id};
	assign gid_s1_ext = {{GW{1'b0}}, item_s1.group_id};
	assign pid_ok_s1  = (pid_s1_ext < (IAW+PW)'(ID_COUNT));
	assign gid_ok_s1  = (gid_s1_ext < (GW+4)'(NUM_GROUPS));

	always_comb begin
		if (clearing_q) begin
			map_we = 1'b1;
			map_wa = clr_addr_q;
			map_wd = '0;
		end else begin
			map_we = item_vld_s1 && (item_s1.command == gfq_pkg::CMD_ASSIGN) &&
				pid_ok_s1 && gid_ok_s1;
			map_wa = pid_s1_ext[IAW-1:0];
			map_wd = gid_s1_ext[GW-1:0];
		end
	end

	// The map is read with the incoming identifier so the group is ready
	// when the command reaches the queue logic.
	gfq_ram #(.WIDTH(GW), .DEPTH(ID_COUNT)) u_map_ram (
		.clk (clk),
		.we  (map_we),
		.wa  (map_wa),
		.wd  (map_wd),
		.ra  (pid_in_ext[IAW-1:0]),
		.rd  (map_rd)
	);

	assign push_grp = pid_ok_s1 ? map_rd : '0;

	gfq_queue_ctl #(.NUM_GROUPS(NUM_GROUPS), .CAPACITY(CAPACITY)) u_queue_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_vld (item_vld_s1),
		.item     (item_s1),
		.push_grp (push_grp),
		.result   (core_result)
	);

	assign valid        = valid_s2;
	assign status       = result_s2.status;
	assign popped_id    = result_s2.popped_id;
	assign popped_group = result_s2.popped_group;

`ifndef SYNTHESIS
	a_result_follows_item: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(start && !busy, 2))
		else $error("result without a matching item");

	a_clear_runs_once: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !busy)
		else $error("busy rose after the clearing sweep");

	a_full_only_on_push: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && (status == gfq_pkg::ST_FULL)) |->
			($past(command, 2) == gfq_pkg::CMD_PUSH))
		else $error("full status for a command that is not a push");
`endif

endmodule

`default_nettype wire
